// ===== design/tnr_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, constants and item types of the triangle normal repair block.
// Depends on nothing; every other file refers to it by scoped names.
package tnr_pkg;

  localparam int COORD_BITS       = 24;
  localparam int NORMAL_FRAC_BITS = 14;
  localparam int NORMAL_W         = 16;
  localparam int CFG_W            = 31;
  localparam int LSQ_W            = 2 * NORMAL_W;
  localparam int EDGE_W           = COORD_BITS + 1;
  localparam int PROD_W           = 2 * EDGE_W;
  localparam int CROSS_W          = PROD_W + 1;
  localparam int MAG_W            = CROSS_W - 1;
  localparam int POS_W            = $clog2(MAG_W);
  localparam int NRM_TOP          = 29;
  localparam int NRM_W            = NRM_TOP + 1;
  localparam int SQ_W             = 2 * NRM_W;
  localparam int SUM_W            = SQ_W + 2;
  localparam int ROOT_W           = SUM_W / 2;
  localparam int QUO_W            = NORMAL_FRAC_BITS + 2;
  localparam int NUM_W            = NRM_W + QUO_W + 1;
  localparam int QUEUE_DEPTH      = 4;
  localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W           = QPTR_W + 1;
  localparam int NORMAL_MAX       = 2 ** (NORMAL_W - 1) - 1;
  localparam int NORMAL_MIN_MAG   = 2 ** (NORMAL_W - 1);

  localparam logic [CFG_W-1:0] MIN_LSQ_RESET = CFG_W'(1);

  typedef struct packed {
    logic [2:0][NORMAL_W-1:0] nrm;
    logic [2:0][EDGE_W-1:0]   e1;
    logic [2:0][EDGE_W-1:0]   e2;
    logic                     recomp;
  } tri_t;

endpackage

// ===== design/tnr_if.sv =====
`timescale 1ns / 1ps
// Request channel interfaces: triangle requests in, normal requests out.
// Depends on tnr_pkg for the coordinate and normal widths.
interface tnr_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [tnr_pkg::NORMAL_W-1:0]   normal_in_x;
  logic signed [tnr_pkg::NORMAL_W-1:0]   normal_in_y;
  logic signed [tnr_pkg::NORMAL_W-1:0]   normal_in_z;
  logic signed [tnr_pkg::COORD_BITS-1:0] vert0_x;
  logic signed [tnr_pkg::COORD_BITS-1:0] vert0_y;
  logic signed [tnr_pkg::COORD_BITS-1:0] vert0_z;
  logic signed [tnr_pkg::COORD_BITS-1:0] vert1_x;
  logic signed [tnr_pkg::COORD_BITS-1:0] vert1_y;
  logic signed [tnr_pkg::COORD_BITS-1:0] vert1_z;
  logic signed [tnr_pkg::COORD_BITS-1:0] vert2_x;
  logic signed [tnr_pkg::COORD_BITS-1:0] vert2_y;
  logic signed [tnr_pkg::COORD_BITS-1:0] vert2_z;

  modport source (
    output valid, normal_in_x, normal_in_y, normal_in_z,
    output vert0_x, vert0_y, vert0_z, vert1_x, vert1_y, vert1_z,
    output vert2_x, vert2_y, vert2_z,
    input  ready
  );
  modport sink (
    input  valid, normal_in_x, normal_in_y, normal_in_z,
    input  vert0_x, vert0_y, vert0_z, vert1_x, vert1_y, vert1_z,
    input  vert2_x, vert2_y, vert2_z,
    output ready
  );
endinterface

interface tnr_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [tnr_pkg::NORMAL_W-1:0] normal_out_x;
  logic signed [tnr_pkg::NORMAL_W-1:0] normal_out_y;
  logic signed [tnr_pkg::NORMAL_W-1:0] normal_out_z;
  logic                                recomputed;
  logic                                degenerate;

  modport source (
    output valid, normal_out_x, normal_out_y, normal_out_z, recomputed, degenerate,
    input  ready
  );
  modport sink (
    input  valid, normal_out_x, normal_out_y, normal_out_z, recomputed, degenerate,
    output ready
  );
endinterface

// ===== design/tnr_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts triangle requests, forms edges, classifies the stored normal.
// Depends on tnr_pkg and tnr_in_if; holds the threshold register.
module tnr_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [tnr_pkg::CFG_W-1:0]   cfg_data,
  tnr_in_if.sink                      in_ch,
  output logic                        push_valid,
  output tnr_pkg::tri_t               push_data,
  input  logic                        push_ready
);

  logic [tnr_pkg::CFG_W-1:0] min_length_sq;
  logic                      f1_valid;
  logic                      f2_valid;
  logic                      en;
  tnr_pkg::tri_t             f1_tri;
  tnr_pkg::tri_t             f1_tri_next;
  tnr_pkg::tri_t             f2_tri;
  tnr_pkg::tri_t             f2_tri_next;
  logic signed [tnr_pkg::LSQ_W-1:0] sq_x, sq_y, sq_z;
  logic signed [tnr_pkg::LSQ_W-1:0] sq_x_next, sq_y_next, sq_z_next;
  logic [tnr_pkg::LSQ_W-1:0] lsq;

  assign en          = !f2_valid || push_ready;
  assign in_ch.ready = en;
  assign push_valid  = f2_valid;
  assign push_data   = f2_tri;

  always_comb begin
    f1_tri_next        = '0;
    f1_tri_next.nrm[0] = in_ch.normal_in_x;
    f1_tri_next.nrm[1] = in_ch.normal_in_y;
    f1_tri_next.nrm[2] = in_ch.normal_in_z;
    f1_tri_next.e1[0]  = tnr_pkg::EDGE_W'(in_ch.vert1_x) - tnr_pkg::EDGE_W'(in_ch.vert0_x);
    f1_tri_next.e1[1]  = tnr_pkg::EDGE_W'(in_ch.vert1_y) - tnr_pkg::EDGE_W'(in_ch.vert0_y);
    f1_tri_next.e1[2]  = tnr_pkg::EDGE_W'(in_ch.vert1_z) - tnr_pkg::EDGE_W'(in_ch.vert0_z);
    f1_tri_next.e2[0]  = tnr_pkg::EDGE_W'(in_ch.vert2_x) - tnr_pkg::EDGE_W'(in_ch.vert0_x);
    f1_tri_next.e2[1]  = tnr_pkg::EDGE_W'(in_ch.vert2_y) - tnr_pkg::EDGE_W'(in_ch.vert0_y);
    f1_tri_next.e2[2]  = tnr_pkg::EDGE_W'(in_ch.vert2_z) - tnr_pkg::EDGE_W'(in_ch.vert0_z);
    sq_x_next          = in_ch.normal_in_x * in_ch.normal_in_x;
    sq_y_next          = in_ch.normal_in_y * in_ch.normal_in_y;
    sq_z_next          = in_ch.normal_in_z * in_ch.normal_in_z;
  end

  assign lsq = sq_x + sq_y + sq_z;

  always_comb begin
    f2_tri_next        = f1_tri;
    f2_tri_next.recomp = lsq < tnr_pkg::LSQ_W'(min_length_sq);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_length_sq <= tnr_pkg::MIN_LSQ_RESET;
    end else if (cfg_we) begin
      min_length_sq <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
    end else if (en) begin
      f1_valid <= in_ch.valid;
      f2_valid <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_tri <= f1_tri_next;
      sq_x   <= sq_x_next;
      sq_y   <= sq_y_next;
      sq_z   <= sq_z_next;
      f2_tri <= f2_tri_next;
    end
  end

endmodule

// ===== design/tnr_queue.sv =====
`timescale 1ns / 1ps
// Short request queue between the front end and the back end.
// Depends on tnr_pkg for the item type and depth.
module tnr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  tnr_pkg::tri_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output tnr_pkg::tri_t pop_data
);

  tnr_pkg::tri_t                mem [tnr_pkg::QUEUE_DEPTH];
  logic [tnr_pkg::QPTR_W-1:0]   wr_ptr;
  logic [tnr_pkg::QPTR_W-1:0]   rd_ptr;
  logic [tnr_pkg::QCNT_W-1:0]   count;
  logic                         do_push;
  logic                         do_pop;

  assign push_ready = count != tnr_pkg::QCNT_W'(tnr_pkg::QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= tnr_pkg::QCNT_W'(tnr_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_fill_full: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop && count == tnr_pkg::QCNT_W'(tnr_pkg::QUEUE_DEPTH - 1))
    |=> !push_ready)
    else $error("queue not full after last free slot taken");

endmodule

// ===== design/tnr_back.sv =====
`timescale 1ns / 1ps
// Back end: cross product, normalising shift, square root and division pipeline.
// Depends on tnr_pkg and tnr_out_if; holds the output register.
module tnr_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  tnr_pkg::tri_t pop_data,
  tnr_out_if.source     out_ch
);

  localparam int S_LOAD  = 0;
  localparam int S_PROD  = 1;
  localparam int S_CROSS = 2;
  localparam int S_MAG   = 3;
  localparam int S_POS   = 4;
  localparam int S_SHIFT = 5;
  localparam int S_SQ    = 6;
  localparam int S_SUM   = 7;
  localparam int S_LEN   = S_SUM + tnr_pkg::ROOT_W + 1;
  localparam int S_LAST  = S_LEN + tnr_pkg::QUO_W;

  typedef struct packed {
    logic [2:0][tnr_pkg::NORMAL_W-1:0] nrm;
    logic                              recomp;
    logic [2:0][tnr_pkg::EDGE_W-1:0]   e1;
    logic [2:0][tnr_pkg::EDGE_W-1:0]   e2;
    logic [5:0][tnr_pkg::PROD_W-1:0]   prod;
    logic [2:0][tnr_pkg::CROSS_W-1:0]  cr;
    logic [2:0][tnr_pkg::MAG_W-1:0]    mag;
    logic [2:0]                        neg;
    logic [tnr_pkg::MAG_W-1:0]         mx;
    logic                              zero;
    logic [tnr_pkg::POS_W-1:0]         pos;
    logic [2:0][tnr_pkg::NRM_W-1:0]    sm;
    logic [2:0][tnr_pkg::SQ_W-1:0]     sq;
    logic [tnr_pkg::SUM_W-1:0]         rem;
    logic [tnr_pkg::ROOT_W-1:0]        root;
    logic [2:0][tnr_pkg::NUM_W-1:0]    drem;
    logic [2:0][tnr_pkg::QUO_W-1:0]    q;
  } work_t;

  work_t              st [0:S_LAST];
  work_t              st_next [0:S_LAST];
  logic [S_LAST:0]    vld;
  logic               en;
  logic               o_valid;
  logic [2:0][tnr_pkg::NORMAL_W-1:0] o_nrm;
  logic [2:0][tnr_pkg::NORMAL_W-1:0] o_nrm_next;
  logic               o_recomp;
  logic               o_deg;

  assign en        = !o_valid || out_ch.ready;
  assign pop_ready = en;

  always_comb begin
    logic signed [tnr_pkg::EDGE_W-1:0] ax, ay, az, bx, by, bz;
    logic [tnr_pkg::CROSS_W-1:0]       negc;
    logic [tnr_pkg::MAG_W-1:0]         sh;
    logic [tnr_pkg::SUM_W-1:0]         t;
    logic [tnr_pkg::NUM_W-1:0]         d;
    int                                b;

    for (int i = 1; i <= S_LAST; i++) begin
      st_next[i] = st[i-1];
    end

    st_next[S_LOAD]        = '0;
    st_next[S_LOAD].nrm    = pop_data.nrm;
    st_next[S_LOAD].recomp = pop_data.recomp;
    st_next[S_LOAD].e1     = pop_data.e1;
    st_next[S_LOAD].e2     = pop_data.e2;

    ax = st[S_PROD-1].e1[0];
    ay = st[S_PROD-1].e1[1];
    az = st[S_PROD-1].e1[2];
    bx = st[S_PROD-1].e2[0];
    by = st[S_PROD-1].e2[1];
    bz = st[S_PROD-1].e2[2];
    st_next[S_PROD].prod[0] = ay * bz;
    st_next[S_PROD].prod[1] = az * by;
    st_next[S_PROD].prod[2] = az * bx;
    st_next[S_PROD].prod[3] = ax * bz;
    st_next[S_PROD].prod[4] = ax * by;
    st_next[S_PROD].prod[5] = ay * bx;

    for (int i = 0; i < 3; i++) begin
      st_next[S_CROSS].cr[i] = $signed(st[S_CROSS-1].prod[2*i])
                             - $signed(st[S_CROSS-1].prod[2*i+1]);
    end

    st_next[S_MAG].mx = '0;
    for (int i = 0; i < 3; i++) begin
      negc                    = -st[S_MAG-1].cr[i];
      st_next[S_MAG].neg[i]   = st[S_MAG-1].cr[i][tnr_pkg::CROSS_W-1];
      st_next[S_MAG].mag[i]   = st_next[S_MAG].neg[i] ? negc[tnr_pkg::MAG_W-1:0]
                                                      : st[S_MAG-1].cr[i][tnr_pkg::MAG_W-1:0];
      if (st_next[S_MAG].mag[i] > st_next[S_MAG].mx) begin
        st_next[S_MAG].mx = st_next[S_MAG].mag[i];
      end
    end
    st_next[S_MAG].zero = st_next[S_MAG].mx == '0;

    st_next[S_POS].pos = '0;
    for (int i = 0; i < tnr_pkg::MAG_W; i++) begin
      if (st[S_POS-1].mx[i]) begin
        st_next[S_POS].pos = tnr_pkg::POS_W'(i);
      end
    end

    for (int i = 0; i < 3; i++) begin
      if (st[S_SHIFT-1].pos > tnr_pkg::POS_W'(tnr_pkg::NRM_TOP)) begin
        sh = st[S_SHIFT-1].mag[i] >> (st[S_SHIFT-1].pos - tnr_pkg::POS_W'(tnr_pkg::NRM_TOP));
      end else begin
        sh = st[S_SHIFT-1].mag[i] << (tnr_pkg::POS_W'(tnr_pkg::NRM_TOP) - st[S_SHIFT-1].pos);
      end
      st_next[S_SHIFT].sm[i] = sh[tnr_pkg::NRM_W-1:0];
    end

    for (int i = 0; i < 3; i++) begin
      st_next[S_SQ].sq[i] = st[S_SQ-1].sm[i] * st[S_SQ-1].sm[i];
    end

    st_next[S_SUM].rem  = tnr_pkg::SUM_W'(st[S_SUM-1].sq[0])
                        + tnr_pkg::SUM_W'(st[S_SUM-1].sq[1])
                        + tnr_pkg::SUM_W'(st[S_SUM-1].sq[2]);
    st_next[S_SUM].root = '0;

    for (int k = 0; k < tnr_pkg::ROOT_W; k++) begin
      b = tnr_pkg::ROOT_W - 1 - k;
      t = (tnr_pkg::SUM_W'(st[S_SUM+k].root) << (b + 1))
        + (tnr_pkg::SUM_W'(1) << (2 * b));
      if (st[S_SUM+k].rem >= t) begin
        st_next[S_SUM+1+k].rem     = st[S_SUM+k].rem - t;
        st_next[S_SUM+1+k].root[b] = 1'b1;
      end
    end

    for (int i = 0; i < 3; i++) begin
      st_next[S_LEN].drem[i] = (tnr_pkg::NUM_W'(st[S_LEN-1].sm[i]) << tnr_pkg::NORMAL_FRAC_BITS)
                             + tnr_pkg::NUM_W'(st[S_LEN-1].root >> 1);
    end
    st_next[S_LEN].q = '0;

    for (int k = 0; k < tnr_pkg::QUO_W; k++) begin
      b = tnr_pkg::QUO_W - 1 - k;
      d = tnr_pkg::NUM_W'(st[S_LEN+k].root) << b;
      for (int i = 0; i < 3; i++) begin
        if (st[S_LEN+k].drem[i] >= d) begin
          st_next[S_LEN+1+k].drem[i] = st[S_LEN+k].drem[i] - d;
          st_next[S_LEN+1+k].q[i][b] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    logic [31:0] qw;
    for (int i = 0; i < 3; i++) begin
      qw = 32'(st[S_LAST].q[i]);
      if (!st[S_LAST].recomp) begin
        o_nrm_next[i] = st[S_LAST].nrm[i];
      end else if (st[S_LAST].zero) begin
        o_nrm_next[i] = '0;
      end else if (st[S_LAST].neg[i]) begin
        if (qw > 32'(tnr_pkg::NORMAL_MIN_MAG)) begin
          o_nrm_next[i] = tnr_pkg::NORMAL_W'(tnr_pkg::NORMAL_MIN_MAG);
        end else begin
          o_nrm_next[i] = tnr_pkg::NORMAL_W'(-qw);
        end
      end else begin
        if (qw > 32'(tnr_pkg::NORMAL_MAX)) begin
          o_nrm_next[i] = tnr_pkg::NORMAL_W'(tnr_pkg::NORMAL_MAX);
        end else begin
          o_nrm_next[i] = qw[tnr_pkg::NORMAL_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      o_valid <= 1'b0;
    end else if (en) begin
      vld     <= {vld[S_LAST-1:0], pop_valid};
      o_valid <= vld[S_LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st       <= st_next;
      o_nrm    <= o_nrm_next;
      o_recomp <= st[S_LAST].recomp;
      o_deg    <= st[S_LAST].recomp && st[S_LAST].zero;
    end
  end

  assign out_ch.valid        = o_valid;
  assign out_ch.normal_out_x = o_nrm[0];
  assign out_ch.normal_out_y = o_nrm[1];
  assign out_ch.normal_out_z = o_nrm[2];
  assign out_ch.recomputed   = o_recomp;
  assign out_ch.degenerate   = o_deg;

  a_deg_needs_recomp: assert property (@(posedge clk) disable iff (rst)
    (o_valid && !o_recomp) |-> !o_deg)
    else $error("degenerate flag on a passed-through normal");

  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    (o_valid && o_deg) |-> (o_nrm[0] == '0 && o_nrm[1] == '0 && o_nrm[2] == '0))
    else $error("degenerate request with non-zero normal");

  a_unit_nonzero: assert property (@(posedge clk) disable iff (rst)
    (o_valid && o_recomp && !o_deg) |-> (o_nrm[0] != '0 || o_nrm[1] != '0 || o_nrm[2] != '0))
    else $error("recomputed normal collapsed to zero");

endmodule

// ===== design/triangle_normal_repair_core.sv =====
`timescale 1ns / 1ps
// Triangle normal repair: one triangle per cycle sustained while the output is not
// stalled, set by the fully pipelined square root (one bit per stage) and divider (one
// quotient bit per stage).
// rst (synchronous) empties the pipeline and queue and sets min_length_sq to 1.
// Depends on tnr_pkg, tnr_if, tnr_front, tnr_queue and tnr_back.
module triangle_normal_repair_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [tnr_pkg::CFG_W-1:0] cfg_data,
  tnr_in_if.sink                    in_ch,
  tnr_out_if.source                 out_ch
);

  logic          push_valid;
  logic          push_ready;
  tnr_pkg::tri_t push_data;
  logic          pop_valid;
  logic          pop_ready;
  tnr_pkg::tri_t pop_data;

  tnr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  tnr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  tnr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

endmodule
